[rtl/fpcvt_pkg.sv]
// ---------------------------------------------------------------------------
// fpcvt_pkg
// Types and constants shared by the single/half precision format converter.
// ---------------------------------------------------------------------------
`default_nettype none

package fpcvt_pkg;

  // Conversion direction codes.
  localparam logic FUNC_NARROW = 1'b0;  // single to half
  localparam logic FUNC_WIDEN  = 1'b1;  // half to single

  // Special bit patterns.
  localparam logic [14:0] HALF_INF   = 15'h7C00;
  localparam logic [14:0] HALF_QUIET = 15'h0200;
  localparam logic [30:0] SGL_INF    = 31'h7F80_0000;

  // Single exponent thresholds for narrowing.
  localparam logic [7:0] SGL_EXP_MAX  = 8'hFF;  // NaN or infinity
  localparam logic [7:0] SGL_EXP_OVF  = 8'd143; // half exponent 31 or more
  localparam logic [7:0] SGL_EXP_TINY = 8'd102; // below this flushes to zero
  localparam logic [7:0] SGL_EXP_SUB  = 8'd112; // at or below: half subnormal
  localparam logic [7:0] SUB_SH_BASE  = 8'd126; // shift = base - exponent
  localparam logic [7:0] EXP_REBIAS   = 8'd112; // 127 - 15

  // Half exponent field of NaN and infinity.
  localparam logic [4:0] HALF_EXP_MAX = 5'h1F;

  // Width of the leading zero count of a half mantissa.
  localparam int LZ_W = 4;

  // Stage 1: decoded operand.
  typedef struct packed {
    logic            func;
    logic            sign;
    logic            fixed;   // result already known
    logic [31:0]     res;     // known result when fixed
    logic            sub;     // narrowing into a half subnormal
    logic [4:0]      sh;      // right shift for a half subnormal
    logic [4:0]      ex;      // half exponent for a normal result
    logic [23:0]     mant;    // single mantissa, or half mantissa in low bits
    logic [LZ_W-1:0] lz;      // leading zeros of a subnormal half mantissa
  } s1_t;

  // Stage 2: shifted mantissa and rounding decision.
  typedef struct packed {
    logic        func;
    logic        fixed;
    logic [31:0] res;
    logic        sign;
    logic [4:0]  ex;
    logic [10:0] q;
    logic        rnd;
  } s2_t;

endpackage

`default_nettype wire

[rtl/fp32_fp16_format_converter.sv]
// ---------------------------------------------------------------------------
// fp32_fp16_format_converter
// IEEE single/half precision bit-pattern converter in a three-stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats carry in_func (0: single to half, 1: half to single) and
//   in_value; a half source is taken from the low 16 bits. Each input beat
//   yields exactly one output beat on out_converted, in order. A half result
//   sits in the low 16 bits with the upper 16 bits zero.
//   Narrowing rounds to nearest even, flushes very small values to signed
//   zero, overflows to signed infinity and turns any NaN into a quiet NaN.
//   Widening is exact.
//   Each beat passes stage registers one, two and three. Unstalled, the
//   pipeline takes one beat per cycle; stage one decodes and counts leading
//   zeros, stage two shifts and decides rounding, stage three adds the round
//   bit. Reset clears all stage valid bits, so no output beat appears until
//   new input arrives. When the receiver holds out_ready low the stages fill
//   up behind the output register and in_ready drops only once all three
//   stages hold a beat; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module fp32_fp16_format_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_converted
);
  import fpcvt_pkg::*;

  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;
  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  logic [31:0] s3_res_r, s3_res_nxt;
  logic        s3_func_r;

  logic [LZ_W-1:0] lz;

  // Stage advance: a stage takes new data when it is empty or draining.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  fpcvt_lzc u_lzc (
    .mant (in_value[9:0]),
    .cnt  (lz)
  );

  // Stage 1: classify the operand and settle the special cases.
  always_comb begin
    logic [7:0] bexp;
    logic [7:0] shf;
    logic [7:0] exn;
    logic [4:0] hex;
    bexp = in_value[30:23];
    shf  = SUB_SH_BASE - bexp;
    exn  = bexp - EXP_REBIAS;
    hex  = in_value[14:10];

    s1_nxt       = '0;
    s1_nxt.func  = in_func;
    s1_nxt.lz    = lz;
    if (in_func == FUNC_NARROW) begin
      s1_nxt.sign = in_value[31];
      s1_nxt.mant = {1'b0, in_value[22:0]};
      if (bexp == SGL_EXP_MAX) begin
        s1_nxt.fixed = 1'b1;
        s1_nxt.res   = {16'b0, in_value[31],
                        HALF_INF | ((in_value[22:0] != '0) ? HALF_QUIET : 15'h0)};
      end else if (bexp >= SGL_EXP_OVF) begin
        s1_nxt.fixed = 1'b1;
        s1_nxt.res   = {16'b0, in_value[31], HALF_INF};
      end else if (bexp < SGL_EXP_TINY) begin
        s1_nxt.fixed = 1'b1;
        s1_nxt.res   = {16'b0, in_value[31], 15'h0};
      end else if (bexp <= SGL_EXP_SUB) begin
        s1_nxt.sub  = 1'b1;
        s1_nxt.sh   = shf[4:0];
        s1_nxt.mant = {1'b1, in_value[22:0]};
      end else begin
        s1_nxt.ex = exn[4:0];
      end
    end else begin
      s1_nxt.sign = in_value[15];
      s1_nxt.mant = {14'b0, in_value[9:0]};
      if (hex == '0) begin
        if (in_value[9:0] == '0) begin
          s1_nxt.fixed = 1'b1;
          s1_nxt.res   = {in_value[15], 31'h0};
        end
      end else if (hex == HALF_EXP_MAX) begin
        s1_nxt.fixed = 1'b1;
        s1_nxt.res   = {in_value[15], SGL_INF | {8'h0, in_value[9:0], 13'h0}};
      end else begin
        s1_nxt.fixed = 1'b1;
        s1_nxt.res   = {in_value[15], {3'b0, hex} + EXP_REBIAS, in_value[9:0], 13'h0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
  end

  // Stage 2: align the mantissa and form guard and sticky bits; widening normalizes here.
  always_comb begin
    logic [23:0] shq;
    logic [23:0] shg;
    logic [23:0] smask;
    logic        guard;
    logic        sticky;
    logic [10:0] nm;
    logic [7:0]  wexp;
    shq    = s1_r.mant >> s1_r.sh;
    shg    = s1_r.mant >> (s1_r.sh - 5'd1);
    smask  = (24'd1 << (s1_r.sh - 5'd1)) - 24'd1;
    nm     = {1'b0, s1_r.mant[9:0]} << ({1'b0, s1_r.lz} + 5'd1);
    wexp   = EXP_REBIAS - {4'b0, s1_r.lz};
    guard  = 1'b0;
    sticky = 1'b0;

    s2_nxt       = '0;
    s2_nxt.func  = s1_r.func;
    s2_nxt.fixed = s1_r.fixed;
    s2_nxt.res   = s1_r.res;
    s2_nxt.sign  = s1_r.sign;
    if (s1_r.func == FUNC_WIDEN) begin
      if (!s1_r.fixed) begin
        s2_nxt.fixed = 1'b1;
        s2_nxt.res   = {s1_r.sign, wexp, nm[9:0], 13'h0};
      end
    end else if (s1_r.sub) begin
      guard       = shg[0];
      sticky      = |(s1_r.mant & smask);
      s2_nxt.ex   = '0;
      s2_nxt.q    = shq[10:0];
      s2_nxt.rnd  = guard && (sticky || shq[0]);
    end else begin
      guard       = s1_r.mant[12];
      sticky      = |s1_r.mant[11:0];
      s2_nxt.ex   = s1_r.ex;
      s2_nxt.q    = {1'b0, s1_r.mant[22:13]};
      s2_nxt.rnd  = guard && (sticky || s1_r.mant[13]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) s2_r <= s2_nxt;
  end

  // Stage 3: add the round bit; a mantissa carry steps the exponent up.
  always_comb begin
    logic [14:0] mag;
    mag = {s2_r.ex, 10'h0} + {4'b0, s2_r.q} + {14'b0, s2_r.rnd};
    if (s2_r.fixed) begin
      s3_res_nxt = s2_r.res;
    end else begin
      s3_res_nxt = {16'b0, s2_r.sign, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_res_r  <= s3_res_nxt;
      s3_func_r <= s2_r.func;
    end
  end

  assign out_valid     = v3_r;
  assign out_converted = s3_res_r;

`ifndef NO_ASSERTIONS
  // A half result never has bits in the upper half-word.
  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (s3_func_r == FUNC_NARROW)) |-> (out_converted[31:16] == 16'h0))
    else $error("narrowed result has upper bits set");

  // An accepted input beat always lands in stage one.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted beat lost at stage one");

  // A stalled output with a full pipeline blocks the input.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is full and stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

[rtl/fpcvt_lzc.sv]
// ---------------------------------------------------------------------------
// fpcvt_lzc
// Leading zero count of a ten-bit half mantissa, used to normalize subnormals.
// ---------------------------------------------------------------------------
`default_nettype none

module fpcvt_lzc (
  input  wire logic [9:0]                  mant,
  output logic      [fpcvt_pkg::LZ_W-1:0]  cnt
);
  import fpcvt_pkg::*;

  // Priority encode the highest set bit; the last match wins.
  always_comb begin
    cnt = LZ_W'(9);
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) begin
        cnt = LZ_W'(9 - i);
      end
    end
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Testbench for the single/half precision format converter. Directed beats
// cover signed zeros, infinities, NaNs, the flush-to-zero boundary, ties and
// rounding carries; zeros, infinities and NaNs in both directions. Random beats
// follow under bursty input and stalling output. A scoreboard predicts each
// converted pattern and checks the results in order.
// ---------------------------------------------------------------------------
module tb;
  import fpcvt_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = FUNC_NARROW;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_converted;

  // Converted patterns still owed by the block, oldest first.
  logic [31:0] expected_converted [$];
  logic [31:0] owed_word;
  int          fail_count = 0;
  int          cycle_count = 0;

  // Sender pacing and receiver behavior, changed from test to test.
  int unsigned burst_left = 0;
  int unsigned max_gap = 0;
  sink_mode_t  sink_mode = SINK_STEADY;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned sink_phase = 0;

  fp32_fp16_format_converter uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_converted(out_converted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Narrow a single pattern to half precision, round to nearest even.
  function automatic logic [15:0] single_to_half(input logic [31:0] bits);
    logic        sign;
    logic [7:0]  bexp;
    logic [23:0] mant;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] halfway;
    int          e;
    int          sh;
    sign = bits[31];
    bexp = bits[30:23];
    mant = {1'b0, bits[22:0]};
    e = int'(bexp) - 112;
    if (bexp == SGL_EXP_MAX) begin
      return {sign, HALF_INF | ((bits[22:0] != 0) ? HALF_QUIET : 15'h0)};
    end
    if (e >= 31) begin
      return {sign, HALF_INF};
    end
    // Half subnormal range: shift in the hidden bit and round the remainder.
    if (e <= 0) begin
      if (e < -10) begin
        return {sign, 15'h0};
      end
      sh = 14 - e;
      mant[23] = 1'b1;
      q = mant >> sh;
      rem = mant & ((24'd1 << sh) - 24'd1);
      halfway = 24'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) begin
        q = q + 24'd1;
      end
      return {sign, q[14:0]};
    end
    // Normal range: drop 13 mantissa bits, a carry bumps the exponent.
    q = mant >> 13;
    rem = mant & 24'h1FFF;
    if (rem > 24'h1000 || (rem == 24'h1000 && q[0])) begin
      q = q + 24'd1;
    end
    if (q == 24'h400) begin
      return {sign, 5'(e + 1), 10'h0};
    end
    return {sign, 5'(e), q[9:0]};
  endfunction

  // Widen a half pattern to single precision; this direction is exact.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [10:0] m;
    logic [7:0]  e;
    ex = h[14:10];
    m = {1'b0, h[9:0]};
    if (ex == 5'h0) begin
      if (m == 11'h0) begin
        return {h[15], 31'h0};
      end
      e = 8'd113;
      while (!m[10]) begin
        m = m << 1;
        e = e - 8'd1;
      end
      return {h[15], e, m[9:0], 13'h0};
    end
    if (ex == HALF_EXP_MAX) begin
      return {h[15], SGL_INF[30:23], h[9:0], 13'h0};
    end
    return {h[15], 8'(ex) + EXP_REBIAS, h[9:0], 13'h0};
  endfunction

  function automatic logic [31:0] converted_of(input logic func, input logic [31:0] value);
    if (func == FUNC_NARROW) begin
      return {16'h0, single_to_half(value)};
    end
    return half_to_single(value[15:0]);
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_value(input logic func, input logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    expected_converted.insert(expected_converted.size(), converted_of(func, value));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Burst pacing: at the start of each burst insert a random gap.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Random operand, weighted toward rounding ties and special exponents.
  task automatic random_operand(output logic func, output logic [31:0] value);
    logic [12:0] low_bits;
    func = 1'($urandom_range(0, 1));
    value = $urandom();
    if (func == FUNC_NARROW) begin
      case ($urandom_range(0, 3))
        0: ;
        1: value[30:23] = 8'($urandom_range(98, 146));
        2: begin
          case ($urandom_range(0, 4))
            0: low_bits = 13'h1000;
            1: low_bits = 13'h0FFF;
            2: low_bits = 13'h1001;
            3: low_bits = 13'h0000;
            default: low_bits = 13'h1FFF;
          endcase
          value[30:23] = 8'($urandom_range(99, 143));
          value[12:0] = low_bits;
        end
        default: value[30:23] = $urandom_range(0, 1) ? SGL_EXP_MAX : 8'h00;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: ;
        1: value[14:10] = 5'h0;
        default: value[14:10] = HALF_EXP_MAX;
      endcase
    end
  endtask

  task automatic send_random(input int unsigned count);
    logic        func;
    logic [31:0] value;
    repeat (count) begin
      pace_sender();
      random_operand(func, value);
      send_value(func, value);
    end
  endtask

  task automatic wait_drained();
    while (expected_converted.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Narrowing corner cases.
  task automatic test_narrow_directed();
    sink_mode = SINK_STEADY;
    send_value(FUNC_NARROW, 32'h0000_0000);  // positive zero
    send_value(FUNC_NARROW, 32'h8000_0000);  // negative zero
    send_value(FUNC_NARROW, 32'h3F80_0000);  // one
    send_value(FUNC_NARROW, 32'h477F_E000);  // largest half
    send_value(FUNC_NARROW, 32'h477F_F000);  // rounds up past the top into infinity
    send_value(FUNC_NARROW, 32'h7F80_0000);  // positive infinity
    send_value(FUNC_NARROW, 32'hFF80_0000);  // negative infinity
    send_value(FUNC_NARROW, 32'h7F80_0001);  // signaling NaN comes out quiet
    send_value(FUNC_NARROW, 32'hFFFF_FFFF);  // negative NaN with full payload
    send_value(FUNC_NARROW, 32'h3380_0000);  // smallest half subnormal
    send_value(FUNC_NARROW, 32'h3300_0001);  // just above the flush boundary
    send_value(FUNC_NARROW, 32'hB2FF_FFFF);  // just below it: signed zero
    send_value(FUNC_NARROW, 32'h0000_0001);  // single subnormal
    send_value(FUNC_NARROW, 32'h387F_FFFF);  // subnormal carries into normal
    send_value(FUNC_NARROW, 32'h3F80_3000);  // tie with odd quotient rounds up
    send_value(FUNC_NARROW, 32'h3FFF_F000);  // mantissa carry bumps the exponent
    release_input();
  endtask

  // Widening corner cases; the upper half of the value must be ignored.
  task automatic test_widen_directed();
    send_value(FUNC_WIDEN, 32'hFFFF_8000);   // negative zero under garbage
    send_value(FUNC_WIDEN, 32'h0000_0001);   // smallest subnormal
    send_value(FUNC_WIDEN, 32'h1234_03FF);   // largest subnormal
    send_value(FUNC_WIDEN, 32'h0000_0400);   // smallest normal
    send_value(FUNC_WIDEN, 32'hABCD_7BFF);   // largest normal
    send_value(FUNC_WIDEN, 32'h0000_FC00);   // negative infinity
    send_value(FUNC_WIDEN, 32'h5555_7C01);   // NaN payload carried over
    send_value(FUNC_WIDEN, 32'h0000_FFFF);   // negative NaN, full payload
    release_input();
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    @(posedge clk);
    sink_mode = SINK_STEADY;
    hold_request = 40;
    max_gap = 0;
    burst_left = 0;
    send_random(16);
    release_input();
    wait_drained();
  endtask

  task automatic test_random_bursty();
    sink_mode = SINK_RANDOM;
    max_gap = 5;
    burst_left = 0;
    send_random(200);
    release_input();
  endtask

  task automatic test_random_pattern();
    sink_mode = SINK_PATTERN;
    max_gap = 2;
    burst_left = 0;
    send_random(120);
    release_input();
  endtask

  task automatic test_random_streaming();
    sink_mode = SINK_STEADY;
    max_gap = 0;
    burst_left = 0;
    send_random(80);
    release_input();
  endtask

  // Receiver: honors a hold-off request, then follows the current mode.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    sink_phase = sink_phase + 1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_STEADY: out_ready <= 1'b1;
        SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:     out_ready <= ((sink_phase % 7) < 4);
      endcase
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_converted.size() == 0) begin
        $error("unexpected result beat: converted=%h", out_converted);
        fail_count++;
      end else begin
        owed_word = expected_converted.pop_front();
        if (out_converted !== owed_word) begin
          $error("converted: expected %h, actual %h", owed_word, out_converted);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fp32_fp16_format_converter: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_narrow_directed();
    test_widen_directed();
    wait_drained();
    test_backpressure();
    test_random_bursty();
    test_random_pattern();
    test_random_streaming();
    wait_drained();
    fail_count += expected_converted.size();
    if (fail_count == 0) begin
      $display("fp32_fp16_format_converter: match");
    end else begin
      $display("fp32_fp16_format_converter: mismatch");
    end
    $finish;
  end

endmodule
